[rtl/core/sha_pkg.sv]
// sha_pkg: shared types and constants of the sha-256 word stream hasher
// round constants, initial hash values and the core control struct
// no dependencies
package sha_pkg;

  localparam int WordW = 32;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic       load_init;
    logic       shift_w;
    logic       round_en;
    logic [5:0] round_idx;
    logic       fin;
    logic       clear;
  } core_ctl_t;

  localparam word_t PadMarker = 32'h80000000;

  function automatic word_t init_hash(input logic [2:0] i);
    case (i)
      3'd0: init_hash = 32'h6a09e667;
      3'd1: init_hash = 32'hbb67ae85;
      3'd2: init_hash = 32'h3c6ef372;
      3'd3: init_hash = 32'ha54ff53a;
      3'd4: init_hash = 32'h510e527f;
      3'd5: init_hash = 32'h9b05688c;
      3'd6: init_hash = 32'h1f83d9ab;
      default: init_hash = 32'h5be0cd19;
    endcase
  endfunction

  function automatic word_t round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    round_k = k[i];
  endfunction

endpackage

[rtl/core/sha_block_mem.sv]
// sha_block_mem: 16-word block buffer, one write and one registered read port
// depends on sha_pkg
module sha_block_mem (
  input  logic          clk,
  input  logic          we,
  input  logic [3:0]    waddr,
  input  sha_pkg::word_t wdata,
  input  logic [3:0]    raddr,
  output sha_pkg::word_t rdata
);
  import sha_pkg::*;

  word_t mem [16];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/sha_core.sv]
// sha_core: message schedule window, round datapath and chaining values
// depends on sha_pkg; fed by the block buffer read port
module sha_core (
  input  logic               clk,
  input  logic               rst,
  input  sha_pkg::core_ctl_t ctl,
  input  sha_pkg::word_t     rd_data,
  input  logic [2:0]         out_idx,
  output sha_pkg::word_t     digest
);
  import sha_pkg::*;

  word_t w  [16];
  word_t v  [8];
  word_t ch [8];

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  word_t s0, s1, w_new, big1, choose, t1, big0, major, t2;

  always_comb begin
    s0     = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1     = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new  = w[0] + s0 + w[9] + s1;
    big1   = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1     = v[7] + big1 + choose + round_k(ctl.round_idx) + w[0];
    big0   = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    major  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2     = big0 + major;
  end

  always_ff @(posedge clk) begin
    if (ctl.shift_w) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= rd_data;
    end else if (ctl.round_en) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) v[i] <= '0;
    end else if (ctl.load_init) begin
      for (int i = 0; i < 8; i++) v[i] <= ch[i];
    end else if (ctl.round_en) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      for (int i = 0; i < 8; i++) ch[i] <= init_hash(3'(i));
    end else if (ctl.fin) begin
      for (int i = 0; i < 8; i++) ch[i] <= ch[i] + v[i];
    end
  end

  assign digest = ch[out_idx];

endmodule

[rtl/core/sha256_word_stream_hasher.sv]
// sha256_word_stream_hasher: top level, input and padding control, digest output
// depends on sha_pkg, sha_block_mem and sha_core
//
// usage:
//   s_* carries message words, one item per word, s_tlast on the final word.
//   m_* returns the eight digest words of a message, index in m_tuser,
//   m_tlast on the eighth word.
// operation:
//   a word is taken only while the block is idle. each full block is read
//   from the block buffer into the schedule window, then runs 64 rounds on
//   the round datapath, then is added into the chaining values. after the
//   final word, padding writes one word per cycle into the block buffer and
//   may take a second block, then the digest is shown one word per cycle
//   while m_tready is high.
// reset:
//   rst clears the word counts and loads the initial hash values.
// stall:
//   while m_tready is low the current digest word holds and no new word
//   is taken until the eighth digest word has gone.
module sha256_word_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // message_word
  input  logic        s_tlast,   // final_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // digest_word
  output logic [2:0]  m_tuser,   // digest_index
  output logic        m_tlast    // digest_done
);
  import sha_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_ROUND = 6'b000100,
    S_FIN   = 6'b001000,
    S_PAD   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t      state;
  logic [3:0]  pos;
  logic [58:0] total;
  logic [5:0]  cnt;
  logic        padding, marker, len_blk;
  logic [2:0]  out_idx;

  logic        we;
  logic [3:0]  waddr;
  word_t       wdata, rd_data, digest;
  core_ctl_t   ctl;
  logic [63:0] bits;

  assign bits = {total, 5'b0};

  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = s_tdata;
    if (state == S_IDLE) begin
      we = s_tvalid;
    end else if (state == S_PAD) begin
      we = 1'b1;
      if (!marker) wdata = PadMarker;
      else if (len_blk && pos == 4'd14) wdata = bits[63:32];
      else if (len_blk && pos == 4'd15) wdata = bits[31:0];
      else wdata = '0;
    end
  end

  always_comb begin
    ctl.load_init = (state == S_LOAD) && (cnt == 6'd0);
    ctl.shift_w   = (state == S_LOAD) && (cnt != 6'd0);
    ctl.round_en  = (state == S_ROUND);
    ctl.round_idx = cnt;
    ctl.fin       = (state == S_FIN);
    ctl.clear     = (state == S_OUT) && m_tready && (out_idx == 3'd7);
  end

  sha_block_mem u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cnt[3:0]),
    .rdata (rd_data)
  );

  sha_core u_core (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .rd_data (rd_data),
    .out_idx (out_idx),
    .digest  (digest)
  );

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = digest;
  assign m_tuser  = out_idx;
  assign m_tlast  = (out_idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pos     <= '0;
      total   <= '0;
      cnt     <= '0;
      padding <= 1'b0;
      marker  <= 1'b0;
      len_blk <= 1'b0;
      out_idx <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            pos   <= pos + 4'd1;
            total <= total + 59'd1;
            cnt   <= '0;
            if (s_tlast) padding <= 1'b1;
            if (pos == 4'd15) state <= S_LOAD;
            else if (s_tlast) state <= S_PAD;
          end
        end
        S_LOAD: begin
          if (cnt == 6'd16) begin
            cnt   <= '0;
            state <= S_ROUND;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_ROUND: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) state <= S_FIN;
        end
        S_FIN: begin
          cnt <= '0;
          if (!padding) state <= S_IDLE;
          else if (marker && len_blk) state <= S_OUT;
          else begin
            if (marker) len_blk <= 1'b1;
            state <= S_PAD;
          end
        end
        S_PAD: begin
          pos <= pos + 4'd1;
          if (!marker) begin
            marker  <= 1'b1;
            len_blk <= (pos <= 4'd13);
          end
          if (pos == 4'd15) begin
            cnt   <= '0;
            state <= S_LOAD;
          end
        end
        S_OUT: begin
          if (m_tready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              pos     <= '0;
              total   <= '0;
              padding <= 1'b0;
              marker  <= 1'b0;
              len_blk <= 1'b0;
              state   <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_write_in_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD || state == S_ROUND) |-> !we)
    else $error("block buffer written during compression");

  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input taken while digest pending");

  a_round_to_fin: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && cnt == 6'd63) |=> (state == S_FIN))
    else $error("round count did not end compression");

  a_pad_then_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (padding && marker && len_blk))
    else $error("digest shown before padding finished");

endmodule
